// ===== hw/rtl/tcw_pkg.sv =====
// shared types, constants and helpers for the text console writer
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  // command queue depth
  localparam int QDEPTH = 2;

  // item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;

  // attribute after reset
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // classified command handed from front to back
  typedef struct packed {
    logic              op_write;
    logic              op_scroll;
    logic              op_clear;
    logic              op_read;
    logic              read_ok;
    logic [IDX_W-1:0]  addr;
    logic [CHAR_W-1:0] chr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  loc;
  } tcw_cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN
  } tcw_state_t;

  // linear cell index of a row and column
  function automatic logic [IDX_W-1:0] cell_loc(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    logic [IDX_W-1:0] base;
    base = IDX_W'(row * COLUMNS);
    return base + IDX_W'(col);
  endfunction

endpackage

// ===== hw/rtl/tcw_front.sv =====
// front end: cursor tracking and classification of accepted words
module tcw_front import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  output logic              push,
  output tcw_cmd_t          cmd
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       col_t;
  logic [5:0]       row_t;

  // decode the word and work out the cursor after it
  always_comb begin
    col_t = {1'b0, col_r};
    row_t = {1'b0, row_r};
    cmd   = '0;
    unique case (kind)
      KIND_PUT: begin
        if (char_code == CH_BS) begin
          if (col_r != '0) col_t = col_t - 8'd1;
        end else if (char_code == CH_TAB) begin
          col_t = 8'(col_t - (col_t % TAB_WIDTH) + TAB_WIDTH);
        end else if (char_code == CH_CR) begin
          col_t = '0;
        end else if (char_code == CH_LF) begin
          col_t = '0;
          row_t = row_t + 6'd1;
        end else if (char_code >= CH_PRINT_LO && char_code <= CH_PRINT_HI) begin
          cmd.op_write = 1'b1;
          cmd.addr     = cell_loc(row_r, col_r);
          col_t        = col_t + 8'd1;
        end
        // wrap to the next row
        if (col_t >= 8'(COLUMNS)) begin
          col_t = '0;
          row_t = row_t + 6'd1;
        end
        // past the last row scrolls
        if (row_t >= 6'(ROWS)) begin
          row_t         = 6'(ROWS - 1);
          cmd.op_scroll = 1'b1;
        end
      end
      KIND_CLEAR: begin
        col_t        = '0;
        row_t        = '0;
        cmd.op_clear = 1'b1;
      end
      KIND_READ: begin
        cmd.op_read = 1'b1;
        cmd.read_ok = (cell_index < IDX_W'(CELLS));
        cmd.addr    = cell_index;
      end
      default: begin
      end
    endcase
    cmd.chr = char_code;
    cmd.col = col_t[COL_W-1:0];
    cmd.row = row_t[ROW_W-1:0];
    cmd.loc = cell_loc(row_t[ROW_W-1:0], col_t[COL_W-1:0]);
    push    = accept;
    col_nxt = accept ? col_t[COL_W-1:0] : col_r;
    row_nxt = accept ? row_t[ROW_W-1:0] : row_r;
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(COLUMNS) && row_r < ROW_W'(ROWS))
    else $error("cursor left the screen");

  // a clear homes the cursor
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == KIND_CLEAR |=> col_r == '0 && row_r == '0)
    else $error("clear did not home the cursor");

  // cell writes stay inside the store
  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    push && cmd.op_write |-> cmd.addr < IDX_W'(CELLS))
    else $error("cell write outside the store");

endmodule

// ===== hw/rtl/tcw_queue.sv =====
// two-entry command queue between front and back
module tcw_queue import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tcw_cmd_t push_cmd,
  input  logic     pop,
  output logic     valid,
  output logic     full,
  output tcw_cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  tcw_cmd_t          ent_r [QDEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    valid    = (cnt_r != '0);
    full     = (cnt_r == CNT_W'(QDEPTH));
    head_cmd = ent_r[rp_r];
    wp_nxt   = push ? PTR_W'(wp_r + 1'b1) : wp_r;
    rp_nxt   = pop ? PTR_W'(rp_r + 1'b1) : rp_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
  end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// back end: cell store, write/read/scroll/clear sequencer and result register
module tcw_back import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tcw_cmd_t          q_cmd,
  input  logic [ATTR_W-1:0] attr,
  output logic              q_pop,
  output logic              init_busy,
  output logic              out_strobe,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [IDX_W-1:0]  out_cursor_addr,
  output logic [CELL_W-1:0] out_cell_value,
  output logic              out_scrolled
);

  logic [CELL_W-1:0] mem [CELLS];

  tcw_state_t        state_r, state_nxt;
  tcw_cmd_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              init_r, init_nxt;
  logic [ATTR_W-1:0] sweep_attr_r, sweep_attr_nxt;
  logic              sw_v_r, sw_v_nxt;
  logic [IDX_W-1:0]  sw_addr_r, sw_addr_nxt;
  logic              sw_copy_r, sw_copy_nxt;
  logic [CELL_W-1:0] rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic              we, we_exec, copy;
  logic [IDX_W-1:0]  waddr;
  logic [CELL_W-1:0] wdata;
  logic              emit;
  logic [CELL_W-1:0] emit_cell;

  logic              strobe_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [IDX_W-1:0]  loc_r;
  logic [CELL_W-1:0] cell_r;
  logic              scrolled_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    init_nxt       = init_r;
    sweep_attr_nxt = sweep_attr_r;
    sw_v_nxt       = 1'b0;
    sw_addr_nxt    = sw_addr_r;
    sw_copy_nxt    = 1'b0;
    q_pop          = 1'b0;
    raddr          = '0;
    we_exec        = 1'b0;
    copy           = 1'b0;
    emit           = 1'b0;
    emit_cell      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        we_exec = cmd_r.op_write;
        if (cmd_r.op_read && cmd_r.read_ok) raddr = cmd_r.addr;
        if (cmd_r.op_scroll || cmd_r.op_clear) begin
          idx_nxt        = '0;
          sweep_attr_nxt = attr;
          state_nxt      = ST_SWEEP;
        end else if (cmd_r.op_read) begin
          state_nxt = ST_READ;
        end else begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_cell = cmd_r.read_ok ? rdata_r : '0;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        // scroll copies the cell one row below, else writes a blank
        copy        = cmd_r.op_scroll && !init_r && (idx_r < IDX_W'(CELLS - COLUMNS));
        if (copy) raddr = IDX_W'(idx_r + COLUMNS);
        sw_v_nxt    = 1'b1;
        sw_addr_nxt = idx_r;
        sw_copy_nxt = copy;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == IDX_W'(CELLS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        emit      = !init_r;
        init_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // single write port: sweep stage or character write
  always_comb begin
    if (sw_v_r) begin
      we    = 1'b1;
      waddr = sw_addr_r;
      wdata = sw_copy_r ? rdata_r : {sweep_attr_r, BLANK_CHAR};
    end else begin
      we    = we_exec;
      waddr = cmd_r.addr;
      wdata = {attr, cmd_r.chr};
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      idx_r        <= '0;
      init_r       <= 1'b1;
      sweep_attr_r <= RESET_ATTR;
      sw_v_r       <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      init_r       <= init_nxt;
      sweep_attr_r <= sweep_attr_nxt;
      sw_v_r       <= sw_v_nxt;
      strobe_r     <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    sw_addr_r <= sw_addr_nxt;
    sw_copy_r <= sw_copy_nxt;
    if (emit) begin
      col_r      <= cmd_r.col;
      row_r      <= cmd_r.row;
      loc_r      <= cmd_r.loc;
      cell_r     <= emit_cell;
      scrolled_r <= cmd_r.op_scroll;
    end
  end

  assign init_busy         = init_r;
  assign out_strobe        = strobe_r;
  assign out_cursor_column = col_r;
  assign out_cursor_row    = row_r;
  assign out_cursor_addr   = loc_r;
  assign out_cell_value    = cell_r;
  assign out_scrolled      = scrolled_r;

  // results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("back-to-back result strobes");

  // sweep writes and character writes never collide
  a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
    sw_v_r |-> !we_exec)
    else $error("two writes to the cell store in one cycle");

  // a scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && scrolled_r |-> row_r == ROW_W'(ROWS - 1))
    else $error("scroll result not on the last row");

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// top level of the text console writer
// An 80x25 store of 16-bit cells (attribute high byte, character low byte)
// with a cursor. After reset busy stays high while the store is swept to
// blanks with attribute 0x0F, one cell per cycle through its single write
// port; cfg writes are taken during that time. A word is taken when start
// is high and busy is low; accepted words queue two deep, so after the
// reset sweep busy rises only while the queue is full. Results come out in
// order, one out_strobe pulse per word, which the receiver must take. A put
// or control character gives its result from the EXEC state after the word
// leaves the queue, a read from the READ state after its registered store
// read; a clear, or any put that scrolls, walks all 2000 cells one per cycle
// and gives its result from the DRAIN state after the sweep.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [IDX_W-1:0]  out_cursor_addr,
  output logic [CELL_W-1:0] out_cell_value,
  output logic              out_scrolled
);

  logic [ATTR_W-1:0] text_attr_r;
  logic              accept;
  logic              push, pop, q_valid, q_full, init_busy;
  tcw_cmd_t          front_cmd, head_cmd;

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= RESET_ATTR;
    end else begin
      if (cfg_we) text_attr_r <= cfg_wdata;
    end
  end

  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_kind),
    .char_code  (in_char_code),
    .cell_index (in_cell_index),
    .push       (push),
    .cmd        (front_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .head_cmd (head_cmd)
  );

  tcw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (head_cmd),
    .attr              (text_attr_r),
    .q_pop             (pop),
    .init_busy         (init_busy),
    .out_strobe        (out_strobe),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_addr   (out_cursor_addr),
    .out_cell_value    (out_cell_value),
    .out_scrolled      (out_scrolled)
  );

endmodule

// ===== bench/text_console_writer_test.sv =====
// testbench for the text console writer: random and directed words, cursor and cell checks
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  // the kind code that the block leaves unused
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int SETTLE_CYCLES = 2100;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  loc;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } cursor_report_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_kind = KIND_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [IDX_W-1:0]  in_cell_index = '0;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;
  logic              out_strobe;
  logic [COL_W-1:0]  out_cursor_column;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [IDX_W-1:0]  out_cursor_addr;
  logic [CELL_W-1:0] out_cell_value;
  logic              out_scrolled;

  // shadow copy of the screen, cursor and attribute
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int                shadow_col;
  int                shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  cursor_report_t    due_reports [$];
  int                bad_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                quiet_phase = 1'b0;

  text_console_writer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_addr   (out_cursor_addr),
    .out_cell_value    (out_cell_value),
    .out_scrolled      (out_scrolled)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_writer_test: done, errors");
      $finish;
    end
  end

  // fill a span of cells with blanks in the current attribute
  function automatic void blank_span(input int from, input int upto);
    int i;
    for (i = from; i < upto && i < CELLS; i++) shadow_cells[i] = {shadow_attr, BLANK_CHAR};
  endfunction

  // advance the shadow console by one word and build the report it should give
  function automatic cursor_report_t apply_word(input logic [1:0] kind,
                                                input logic [CHAR_W-1:0] code,
                                                input logic [IDX_W-1:0] idx);
    cursor_report_t rep;
    int at;
    int i;
    rep.cell_val = '0;
    rep.scrolled = 1'b0;
    case (kind)
      KIND_PUT: begin
        if (code == CH_BS) begin
          if (shadow_col > 0) shadow_col--;
        end else if (code == CH_TAB) begin
          shadow_col = shadow_col + TAB_WIDTH - (shadow_col % TAB_WIDTH);
        end else if (code == CH_CR) begin
          shadow_col = 0;
        end else if (code == CH_LF) begin
          shadow_col = 0;
          shadow_row++;
        end else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
          at = shadow_row * COLUMNS + shadow_col;
          if (at < CELLS) shadow_cells[at] = {shadow_attr, code};
          shadow_col++;
        end
        // wrap at the right edge
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
        // scroll up one line past the bottom row
        if (shadow_row >= ROWS) begin
          for (i = 0; i + COLUMNS < CELLS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          blank_span((ROWS - 1) * COLUMNS, CELLS);
          shadow_row = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        blank_span(0, CELLS);
        shadow_col = 0;
        shadow_row = 0;
      end
      KIND_READ: begin
        if (idx < CELLS) rep.cell_val = shadow_cells[idx];
      end
      default: ;
    endcase
    rep.col = COL_W'(shadow_col);
    rep.row = ROW_W'(shadow_row);
    rep.loc = IDX_W'(shadow_row * COLUMNS + shadow_col);
    return rep;
  endfunction

  // send one word, idling between bursts, and record what it should report
  task automatic send_word(input logic [1:0] kind, input logic [CHAR_W-1:0] code,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = quiet_phase ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_char_code <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
    due_reports.push_back(apply_word(kind, code, idx));
  endtask

  // write the attribute once every outstanding report is in
  task automatic set_attribute(input logic [ATTR_W-1:0] attr);
    start <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= attr;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_attr = attr;
    burst_left = 0;
    quiet_phase = ($urandom_range(0, 3) == 0);
  endtask

  function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
                                      input logic [CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_count++;
    end
  endfunction

  // compare each report with the oldest outstanding word
  always @(posedge clk) begin : check_reports
    cursor_report_t want;
    if (rst_n && out_strobe) begin
      if (due_reports.size() == 0) begin
        $error("report with no word outstanding: column %0d row %0d",
               out_cursor_column, out_cursor_row);
        bad_count++;
      end else begin
        want = due_reports.pop_front();
        check_field("cursor_column", CELL_W'(want.col), CELL_W'(out_cursor_column));
        check_field("cursor_row", CELL_W'(want.row), CELL_W'(out_cursor_row));
        check_field("cursor_addr", CELL_W'(want.loc), CELL_W'(out_cursor_addr));
        check_field("cell_value", want.cell_val, out_cell_value);
        check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(out_scrolled));
      end
    end
  end

  // blank store after reset, reads past the end, the unused kind
  task automatic test_reset_state();
    send_word(KIND_READ, CHAR_W'($urandom), '0);
    send_word(KIND_READ, CHAR_W'($urandom), IDX_W'(CELLS - 1));
    send_word(KIND_READ, CHAR_W'($urandom), IDX_W'(CELLS));
    send_word(KIND_READ, CHAR_W'($urandom), '1);
    send_word(KIND_SPARE, '1, '1);
  endtask

  // printable extremes, ignored bytes and every control code
  task automatic test_put_codes();
    send_word(KIND_PUT, 8'h41, '0);
    send_word(KIND_PUT, CH_PRINT_LO, '0);
    send_word(KIND_PUT, CH_PRINT_HI, '0);
    send_word(KIND_PUT, 8'h80, '1);
    send_word(KIND_PUT, 8'hFF, '0);
    send_word(KIND_PUT, 8'h00, '0);
    send_word(KIND_PUT, 8'h1F, '0);
    send_word(KIND_PUT, CH_BS, '0);
    send_word(KIND_PUT, CH_CR, '0);
    // backspace at the left edge does nothing
    send_word(KIND_PUT, CH_BS, '0);
    send_word(KIND_PUT, CH_TAB, '0);
    send_word(KIND_PUT, CH_LF, '0);
    send_word(KIND_READ, 8'h00, IDX_W'(0));
    send_word(KIND_READ, 8'h00, IDX_W'(2));
    send_word(KIND_CLEAR, 8'h41, '0);
    send_word(KIND_READ, 8'h00, IDX_W'(0));
  endtask

  // short lines down past the bottom, then edge wrap and tab wrap at the bottom row
  task automatic test_scroll();
    int n;
    repeat (28) begin
      n = $urandom_range(0, 5);
      repeat (n) send_word(KIND_PUT, CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)),
                           IDX_W'($urandom));
      send_word(KIND_PUT, CH_LF, IDX_W'($urandom));
    end
    send_word(KIND_READ, 8'h00, IDX_W'((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1)));
    send_word(KIND_READ, 8'h00, IDX_W'((ROWS - 2) * COLUMNS + $urandom_range(0, 5)));
    repeat (COLUMNS + $urandom_range(1, 8))
      send_word(KIND_PUT, CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)), IDX_W'($urandom));
    send_word(KIND_PUT, CH_CR, IDX_W'($urandom));
    repeat (COLUMNS / TAB_WIDTH + 1) send_word(KIND_PUT, CH_TAB, IDX_W'($urandom));
    send_word(KIND_READ, 8'h00, IDX_W'((ROWS - 1) * COLUMNS + $urandom_range(0, 3)));
    send_word(KIND_READ, 8'h00, IDX_W'((ROWS - 2) * COLUMNS + $urandom_range(0, COLUMNS - 1)));
  endtask

  // mostly text with controls, reads near the cursor and across the store
  task automatic test_random_traffic(input int count);
    int pick;
    int at;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] code;
    logic [IDX_W-1:0]  idx;
    repeat (count) begin
      pick = $urandom_range(0, 199);
      kind = KIND_PUT;
      code = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      idx = IDX_W'($urandom);
      if (pick < 16) code = CH_LF;
      else if (pick < 22) code = CH_CR;
      else if (pick < 30) code = CH_TAB;
      else if (pick < 38) code = CH_BS;
      else if (pick < 44) code = CHAR_W'($urandom_range(0, 31));
      else if (pick < 50) code = CHAR_W'($urandom_range(128, 255));
      else if (pick < 51) begin
        kind = KIND_CLEAR;
        code = CHAR_W'($urandom);
      end else if (pick < 53) begin
        kind = KIND_SPARE;
        code = CHAR_W'($urandom);
      end else if (pick < 70) begin
        // just behind the cursor, where text was last written
        kind = KIND_READ;
        code = CHAR_W'($urandom);
        at = shadow_row * COLUMNS + shadow_col - $urandom_range(0, 8);
        idx = IDX_W'((at < 0) ? 0 : at);
      end else if (pick < 90) begin
        kind = KIND_READ;
        code = CHAR_W'($urandom);
      end
      send_word(kind, code, idx);
    end
  endtask

  // stimulus
  initial begin
    shadow_attr = RESET_ATTR;
    shadow_col = 0;
    shadow_row = 0;
    blank_span(0, CELLS);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_put_codes();
    set_attribute(8'h00);
    test_scroll();
    set_attribute(8'hFF);
    test_scroll();
    set_attribute(ATTR_W'($urandom));
    test_random_traffic(110);
    set_attribute(ATTR_W'($urandom));
    test_random_traffic(110);
    set_attribute(ATTR_W'($urandom));
    test_random_traffic(110);
    set_attribute(RESET_ATTR);
    test_random_traffic(110);

    start <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("text_console_writer_test: done, clean");
    end else begin
      $display("text_console_writer_test: done, errors");
    end
    $finish;
  end

endmodule
